>>> src/fqvr_pkg.sv
// Shared constants, codes and controller/datapath link types for the value-removal queue.
`default_nettype none

package fqvr_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = IDX_W + 1;
   localparam int WORD_W = 32;
   localparam int ACT_W  = 3;
   localparam int STS_W  = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH    = 3'd0,
      ACT_POP     = 3'd1,
      ACT_REMOVE  = 3'd2,
      ACT_CLEAR   = 3'd3,
      ACT_INSPECT = 3'd4
   } action_type;

   typedef enum logic [STS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic scan;
      logic head_rd;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_remove;
      logic scan_done;
   } sts_type;

endpackage

`default_nettype wire

>>> src/fqvr_if.sv
// Request and response channel interfaces of the value-removal queue.
`default_nettype none

interface fqvr_req_if;
   logic                               valid;
   logic                               ready;
   logic [fqvr_pkg::ACT_W-1:0]         action;
   logic signed [fqvr_pkg::WORD_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

interface fqvr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [fqvr_pkg::WORD_W-1:0] popped_word;
   logic signed [fqvr_pkg::WORD_W-1:0] head_word;
   logic [fqvr_pkg::CNT_W-1:0]         length;
   logic [fqvr_pkg::STS_W-1:0]         status;

   modport source (output valid, output popped_word, output head_word, output length,
                   output status, input ready);
   modport sink (input valid, input popped_word, input head_word, input length,
                 input status, output ready);
endinterface

`default_nettype wire

>>> src/fifo_queue_with_value_removal.sv
// Top level: bounded FIFO of 32-bit words with push, pop, value removal, clear and inspect.
// Push, pop, clear and inspect pass through the execute, head-read and done states; the next
// request is taken only back in idle. A removal adds a scan of the ring by the single read port.
// A response waits in an output register; the next request is taken while it is not yet drained.
// Synchronous active-high reset empties the queue and drops any pending response; stored words
// are not cleared, and a word that was never written never reaches a response.
`default_nettype none

module fifo_queue_with_value_removal (
   input logic      clock,
   input logic      reset,
   fqvr_req_if.sink   req_ch,
   fqvr_rsp_if.source rsp_ch
);
   import fqvr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fqvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fqvr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_ch.action),
      .req_value       (req_ch.value),
      .rsp_popped_word (rsp_ch.popped_word),
      .rsp_head_word   (rsp_ch.head_word),
      .rsp_length      (rsp_ch.length),
      .rsp_status      (rsp_ch.status)
   );

endmodule

`default_nettype wire

>>> src/fqvr_ctrl.sv
// Sequencing state machine of the value-removal queue.
`default_nettype none

module fqvr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fqvr_pkg::cmd_type cmd,
   input  fqvr_pkg::sts_type sts
);
   import fqvr_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_SCAN = 5'b00100,
      S_HEAD = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.is_remove ? S_SCAN : S_HEAD;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> src/fqvr_dp.sv
// Ring storage, pointers, removal scan and response registers of the value-removal queue.
`default_nettype none

module fqvr_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  fqvr_pkg::cmd_type                  cmd,
   output fqvr_pkg::sts_type                  sts,
   input  logic [fqvr_pkg::ACT_W-1:0]         req_action,
   input  logic signed [fqvr_pkg::WORD_W-1:0] req_value,
   output logic signed [fqvr_pkg::WORD_W-1:0] rsp_popped_word,
   output logic signed [fqvr_pkg::WORD_W-1:0] rsp_head_word,
   output logic [fqvr_pkg::CNT_W-1:0]         rsp_length,
   output logic [fqvr_pkg::STS_W-1:0]         rsp_status
);
   import fqvr_pkg::*;

   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   logic [ACT_W-1:0]  act_ff;
   logic [WORD_W-1:0] val_ff;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_i_ff, rd_i_in;
   logic [CNT_W-1:0]  kept_ff, kept_in;
   logic              pend_ff, pend_in;
   logic [WORD_W-1:0] popped_ff, popped_in;
   status_type        status_ff, status_in;

   logic [WORD_W-1:0] out_popped_ff;
   logic [WORD_W-1:0] out_head_ff;
   logic [CNT_W-1:0]  out_length_ff;
   status_type        out_status_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;

   assign sts.is_remove = (act_ff == ACT_REMOVE);
   assign sts.scan_done = (rd_i_ff == count_ff) && !pend_ff;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      rd_i_in   = rd_i_ff;
      kept_in   = kept_ff;
      pend_in   = pend_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      wr_en     = 1'b0;
      wr_addr   = ring_pos(head_ff, count_ff);
      wr_data   = val_ff;
      if (cmd.latch) begin
         rd_en = 1'b1;
      end else if (cmd.exec) begin
         popped_in = '0;
         status_in = ST_OK;
         rd_i_in   = '0;
         kept_in   = '0;
         pend_in   = 1'b0;
         unique case (act_ff)
            ACT_PUSH: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  popped_in = rdata_ff;
                  head_in   = ring_pos(head_ff, CNT_W'(1));
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            ACT_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.scan) begin
         if (rd_i_ff < count_ff) begin
            rd_en   = 1'b1;
            rd_addr = ring_pos(head_ff, rd_i_ff);
            rd_i_in = rd_i_ff + CNT_W'(1);
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff && (rdata_ff != val_ff)) begin
            wr_en   = 1'b1;
            wr_addr = ring_pos(head_ff, kept_ff);
            wr_data = rdata_ff;
            kept_in = kept_ff + CNT_W'(1);
         end
         if (sts.scan_done) begin
            count_in = kept_ff;
         end
      end else if (cmd.head_rd) begin
         rd_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff <= req_action;
         val_ff <= req_value;
      end
      rd_i_ff   <= rd_i_in;
      kept_ff   <= kept_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      if (cmd.load_rsp) begin
         out_popped_ff <= popped_ff;
         out_head_ff   <= (count_ff != '0) ? rdata_ff : '0;
         out_length_ff <= count_ff;
         out_status_ff <= status_ff;
      end
   end

   assign rsp_popped_word = out_popped_ff;
   assign rsp_head_word   = out_head_ff;
   assign rsp_length      = out_length_ff;
   assign rsp_status      = out_status_ff;

endmodule

`default_nettype wire

>>> src/fqvr_chk.sv
// Port-level checker of the value-removal queue and its binding to the top level.
`default_nettype none

module fqvr_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [fqvr_pkg::WORD_W-1:0]  rsp_popped_word,
   input logic [fqvr_pkg::WORD_W-1:0]  rsp_head_word,
   input logic [fqvr_pkg::CNT_W-1:0]   rsp_length,
   input logic [fqvr_pkg::STS_W-1:0]   rsp_status
);
   import fqvr_pkg::*;

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length <= CNT_W'(DEPTH)))
      else $error("Response length exceeds the queue depth.");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_length == CNT_W'(DEPTH)))
      else $error("Dropped push reported while the queue was not full.");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY)) |-> ((rsp_length == '0) && (rsp_popped_word == '0)))
      else $error("Pop on empty reported with stored entries or a non-zero word.");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_length == '0)) |-> (rsp_head_word == '0))
      else $error("Empty queue reported a non-zero head word.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_popped_word)
                                     && $stable(rsp_head_word) && $stable(rsp_length)
                                     && $stable(rsp_status)))
      else $error("Stalled response changed or was withdrawn.");

endmodule

bind fifo_queue_with_value_removal fqvr_chk u_fqvr_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_popped_word (rsp_ch.popped_word),
   .rsp_head_word   (rsp_ch.head_word),
   .rsp_length      (rsp_ch.length),
   .rsp_status      (rsp_ch.status)
);

`default_nettype wire

>>> test/fifo_queue_with_value_removal_test.sv
// Self-checking testbench for the value-removal queue, with a built-in predictor and random traffic.
`timescale 1ns / 1ps

module fifo_queue_with_value_removal_test;
   import fqvr_pkg::*;

   localparam logic [ACT_W-1:0] ACT_RESERVED_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_RESERVED_HI = 3'd7;
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_word;
      logic signed [WORD_W-1:0] head_word;
      logic [CNT_W-1:0]         length;
      logic [STS_W-1:0]         status;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fqvr_req_if req_ch ();
   fqvr_rsp_if rsp_ch ();

   fifo_queue_with_value_removal dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic signed [WORD_W-1:0] ring_words [DEPTH];
   int ring_head = 0;
   int ring_count = 0;

   queue_reply_type pending_replies[$];
   queue_reply_type oldest_reply;

   int sender_idle_pct = 10;
   int receiver_idle_pct = 53;
   int hold_off_cycles = 0;
   int error_count = 0;
   int request_count = 0;
   int reply_count = 0;
   int removal_count = 0;
   int full_drop_count = 0;
   int empty_pop_count = 0;
   int max_length_seen = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic queue_reply_type predict_reply(input logic [ACT_W-1:0] act,
                                                     input logic signed [WORD_W-1:0] val);
      queue_reply_type reply;
      int i;
      int kept;
      logic signed [WORD_W-1:0] word;
      reply = '0;
      reply.status = ST_OK;
      case (act)
         ACT_PUSH: begin
            if (ring_count >= DEPTH) begin
               reply.status = ST_FULL;
               full_drop_count++;
            end else begin
               ring_words[(ring_head + ring_count) % DEPTH] = val;
               ring_count++;
            end
         end
         ACT_POP: begin
            if (ring_count == 0) begin
               reply.status = ST_EMPTY;
               empty_pop_count++;
            end else begin
               reply.popped_word = ring_words[ring_head];
               ring_head = (ring_head + 1) % DEPTH;
               ring_count--;
            end
         end
         ACT_REMOVE: begin
            kept = 0;
            for (i = 0; i < ring_count; i++) begin
               word = ring_words[(ring_head + i) % DEPTH];
               if (word != val) begin
                  ring_words[(ring_head + kept) % DEPTH] = word;
                  kept++;
               end
            end
            ring_count = kept;
            removal_count++;
         end
         ACT_CLEAR: begin
            ring_head = 0;
            ring_count = 0;
         end
         default: begin
         end
      endcase
      reply.head_word = (ring_count != 0) ? ring_words[ring_head] : '0;
      reply.length = ring_count[CNT_W-1:0];
      if (ring_count > max_length_seen) begin
         max_length_seen = ring_count;
      end
      return reply;
   endfunction

   task automatic send_request(input logic [ACT_W-1:0] act, input logic signed [WORD_W-1:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.action = act;
      req_ch.value = val;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      pending_replies.push_back(predict_reply(act, val));
      request_count++;
      @(negedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] pick_value();
      int choice;
      choice = $urandom_range(9);
      if (choice < 4) begin
         return $signed($urandom_range(5)) - 2;
      end else if (choice < 7 && ring_count != 0) begin
         return ring_words[(ring_head + $urandom_range(ring_count - 1)) % DEPTH];
      end
      return $urandom;
   endfunction

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         reply_count++;
         if (pending_replies.size() == 0) begin
            $error("response arrived with no request outstanding");
            error_count++;
         end else begin
            oldest_reply = pending_replies.pop_front();
            if (rsp_ch.popped_word !== oldest_reply.popped_word) begin
               $error("popped_word: expected %0d, got %0d", oldest_reply.popped_word,
                      rsp_ch.popped_word);
               error_count++;
            end
            if (rsp_ch.head_word !== oldest_reply.head_word) begin
               $error("head_word: expected %0d, got %0d", oldest_reply.head_word,
                      rsp_ch.head_word);
               error_count++;
            end
            if (rsp_ch.length !== oldest_reply.length) begin
               $error("length: expected %0d, got %0d", oldest_reply.length, rsp_ch.length);
               error_count++;
            end
            if (rsp_ch.status !== oldest_reply.status) begin
               $error("status: expected %0d, got %0d", oldest_reply.status, rsp_ch.status);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed_corners();
      int i;
      send_request(ACT_POP, '0);
      send_request(ACT_REMOVE, 32'sd5);
      send_request(ACT_PUSH, WORD_MIN);
      send_request(ACT_PUSH, WORD_MAX);
      send_request(ACT_PUSH, '0);
      send_request(ACT_PUSH, -32'sd1);
      send_request(ACT_POP, '0);
      for (i = 0; i < 13; i++) begin
         send_request(ACT_PUSH, (i % 3 == 0) ? 32'sd7 : 32'(i));
      end
      send_request(ACT_PUSH, 32'sd99);
      send_request(ACT_REMOVE, 32'sd7);
      send_request(ACT_INSPECT, WORD_MAX);
      send_request(ACT_RESERVED_HI, '0);
      send_request(ACT_CLEAR, '0);
   endtask

   task automatic test_mixed_traffic(input int item_total);
      int n;
      int pick;
      int push_share;
      logic [ACT_W-1:0] act;
      for (n = 0; n < item_total; n++) begin
         push_share = ((n / 100) % 2 == 0) ? 60 : 30;
         pick = $urandom_range(99);
         if (pick < push_share) begin
            act = ACT_PUSH;
         end else if (pick < push_share + 25) begin
            act = ACT_POP;
         end else if (pick < push_share + 33) begin
            act = ACT_REMOVE;
         end else if (pick < push_share + 35) begin
            act = ACT_CLEAR;
         end else if (pick < push_share + 38) begin
            act = ACT_INSPECT;
         end else begin
            act = ACT_W'($urandom_range(ACT_RESERVED_HI, ACT_RESERVED_LO));
         end
         send_request(act, pick_value());
      end
   endtask

   task automatic test_output_backpressure();
      int n;
      sender_idle_pct = 0;
      hold_off_cycles = 300;
      for (n = 0; n < 40; n++) begin
         send_request((n % 4 == 3) ? ACT_POP : ACT_PUSH, pick_value());
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = ACT_INSPECT;
      req_ch.value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      sender_idle_pct = 10;
      receiver_idle_pct = 53;
      test_directed_corners();
      test_mixed_traffic(570);
      test_output_backpressure();
      sender_idle_pct = 53;
      receiver_idle_pct = 10;
      test_mixed_traffic(570);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_mixed_traffic(560);
      req_ch.valid = 1'b0;

      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses, including %0d removals.",
               request_count, reply_count, removal_count);
      $display("Saw %0d pushes dropped when full, %0d pops on empty, peak length %0d.",
               full_drop_count, empty_pop_count, max_length_seen);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
